// File: rtl/wfpd_pkg.sv
// package for the wall-follow pd steering core: register codes, constants, helpers
`default_nettype none
package wfpd_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // register indexes of the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_FOLLOW_LEFT   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_TARGET_LEFT   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_TARGET_RIGHT  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_BASE_SPEED    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_PROP_GAIN     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_DERIV_GAIN    = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_FRONT_GAIN    = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_WALL_FRACTION = 3'd7;

  // reset values of the registers
  localparam logic               RST_FOLLOW_LEFT   = 1'b0;
  localparam logic [11:0]        RST_TARGET_LEFT   = 12'd0;
  localparam logic [11:0]        RST_TARGET_RIGHT  = 12'd0;
  localparam logic signed [10:0] RST_BASE_SPEED    = 11'sd70;
  localparam logic [15:0]        RST_PROP_GAIN     = 16'd77;
  localparam logic [15:0]        RST_DERIV_GAIN    = 16'd2560;
  localparam logic [15:0]        RST_FRONT_GAIN    = 16'd333;
  localparam logic [8:0]         RST_WALL_FRACTION = 9'd84;

  localparam logic [11:0] FRONT_LIMIT  = 12'd500;
  localparam logic [15:0] LOST_RESTART = 16'd70;
  localparam logic [15:0] LOST_MAX     = 16'd32767;

  localparam logic signed [34:0] S16_MAX = 35'sd32767;
  localparam logic signed [34:0] S16_MIN = -35'sd32768;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_THRESH = 9'b000000010,
    ST_SEEN   = 9'b000000100,
    ST_FRONT  = 9'b000001000,
    ST_PROP   = 9'b000010000,
    ST_DERIV  = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_CORR   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7fff;
    end else if (v < S16_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // divide by 256, rounding toward zero
  function automatic logic signed [34:0] div256_trunc(input logic signed [34:0] v);
    logic signed [34:0] r;
    if (v < 35'sd0) begin
      r = (v + 35'sd255) >>> 8;
    end else begin
      r = v >>> 8;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/wall_follow_pd_steering_core.sv
// wall-follow pd steering core: sequencer around one shared 17x17 multiplier
//
//  channel   signals                                         direction
//  cfg       cfg_we, cfg_index, cfg_data                     in
//  in        in_valid, in_stall, four 12-bit samples          in  (stall out)
//  out       out_valid, out_stall, two speeds, front flag     out (stall in)
//
// an item is accepted and then runs eight sequencer steps, whose order is set by the
// four products (threshold, front, kp, kd) passing through the one multiplier
// with a register behind it. in_stall is high from accept until the result is
// loaded into the output register; a result stalled downstream holds the last
// step until the register frees. rst is synchronous and restores register
// defaults and clears last_error and lost_wall_error.
`default_nettype none
module wall_follow_pd_steering_core
  import wfpd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [11:0]              front_left_sample,
  input  wire logic [11:0]              side_right_sample,
  input  wire logic [11:0]              side_left_sample,
  input  wire logic [11:0]              front_right_sample,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [15:0]            left_motor_speed,
  output logic signed [15:0]            right_motor_speed,
  output logic                          front_wall_seen
);

  logic               follow_left;
  logic [11:0]        target_left;
  logic [11:0]        target_right;
  logic signed [10:0] base_speed;
  logic [15:0]        prop_gain;
  logic [15:0]        deriv_gain;
  logic [15:0]        front_gain;
  logic [8:0]         wall_fraction;

  state_t state;

  logic [11:0]        fl;
  logic [11:0]        fr;
  logic [11:0]        side;
  logic [11:0]        target;
  logic               front;
  logic signed [12:0] excess;
  logic signed [15:0] err;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [34:0] acc;
  logic signed [15:0] corr;
  logic signed [15:0] last_error;
  logic [15:0]        lost_wall_error;

  logic [15:0]        mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;

  logic [12:0]        front_sum;
  logic signed [34:0] front_x;
  logic signed [15:0] corr_raw;
  logic signed [16:0] corr_neg;
  logic signed [17:0] left_sum;
  logic signed [17:0] right_sum;
  logic               out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      follow_left   <= RST_FOLLOW_LEFT;
      target_left   <= RST_TARGET_LEFT;
      target_right  <= RST_TARGET_RIGHT;
      base_speed    <= RST_BASE_SPEED;
      prop_gain     <= RST_PROP_GAIN;
      deriv_gain    <= RST_DERIV_GAIN;
      front_gain    <= RST_FRONT_GAIN;
      wall_fraction <= RST_WALL_FRACTION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOLLOW_LEFT:   follow_left   <= cfg_data[0];
        REG_TARGET_LEFT:   target_left   <= cfg_data[11:0];
        REG_TARGET_RIGHT:  target_right  <= cfg_data[11:0];
        REG_BASE_SPEED:    base_speed    <= cfg_data[10:0];
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
        REG_FRONT_GAIN:    front_gain    <= cfg_data;
        REG_WALL_FRACTION: wall_fraction <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_THRESH: begin
        mul_a = {7'd0, wall_fraction};
        mul_b = {5'd0, target};
      end
      ST_SEEN: begin
        mul_a = front_gain;
        mul_b = 17'(excess);
      end
      ST_PROP: begin
        mul_a = prop_gain;
        mul_b = 17'(err);
      end
      ST_DERIV: begin
        mul_a = deriv_gain;
        mul_b = diff;
      end
      default: ;
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    front_sum = {1'b0, fl} + {1'b0, fr};
    front_x   = (35'(err) <<< 8) - 35'(prod);
    corr_raw  = sat16(div256_trunc(acc));
    corr_neg  = -17'(corr_raw);
    left_sum  = 18'(base_speed) - 18'(corr);
    right_sum = 18'(base_speed) + 18'(corr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      last_error      <= '0;
      lost_wall_error <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            fl     <= front_left_sample;
            fr     <= front_right_sample;
            side   <= follow_left ? side_left_sample : side_right_sample;
            target <= follow_left ? target_left : target_right;
            front  <= (front_left_sample > FRONT_LIMIT) &&
                      (front_right_sample > FRONT_LIMIT);
            state  <= ST_THRESH;
          end
        end
        ST_THRESH: begin
          prod   <= mul_p;
          excess <= $signed({1'b0, front_sum[12:1]}) - $signed({1'b0, FRONT_LIMIT});
          state  <= ST_SEEN;
        end
        ST_SEEN: begin
          // wall seen when side * 256 beats target * fraction
          if ($signed({14'd0, side, 8'd0}) > prod) begin
            err             <= 16'($signed({1'b0, target}) - $signed({1'b0, side}));
            lost_wall_error <= LOST_RESTART;
          end else begin
            err <= $signed(lost_wall_error);
            if (lost_wall_error >= LOST_MAX) begin
              lost_wall_error <= LOST_MAX;
            end else begin
              lost_wall_error <= lost_wall_error + 16'd1;
            end
          end
          prod  <= mul_p;
          state <= ST_FRONT;
        end
        ST_FRONT: begin
          if (front) begin
            err <= sat16(div256_trunc(front_x));
          end
          state <= ST_PROP;
        end
        ST_PROP: begin
          prod  <= mul_p;
          diff  <= 17'(err) - 17'(last_error);
          state <= ST_DERIV;
        end
        ST_DERIV: begin
          acc   <= 35'(prod);
          prod  <= mul_p;
          state <= ST_SUM;
        end
        ST_SUM: begin
          acc   <= acc + 35'(prod);
          state <= ST_CORR;
        end
        ST_CORR: begin
          last_error <= err;
          // right-hand follow flips the sign, saturating -32768
          if (follow_left) begin
            corr <= corr_raw;
          end else begin
            corr <= sat16(35'(corr_neg));
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            left_motor_speed  <= sat16(35'(left_sum));
            right_motor_speed <= sat16(35'(right_sum));
            front_wall_seen   <= front;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
